>>> sv/lmap_pkg.sv
// ----------------------------------------------------------------------------
// lmap_pkg: shared types and constants for the lightmap sampler
// Payload structs for the item and result channels, register indexes,
// opcodes and default sizes.
// ----------------------------------------------------------------------------
package lmap_pkg;

    // Default sizes
    localparam int DEF_MAX_LAYERS  = 4;
    localparam int DEF_TEXEL_DEPTH = 4096;
    localparam int DEF_MAX_DIM     = 32;

    // Field widths
    localparam int DIM_W    = 6;
    localparam int COUNT_W  = 3;
    localparam int SCALE_W  = 15;
    localparam int INDEX_W  = 12;
    localparam int COORD_W  = 16;
    localparam int LIGHT_W  = 21;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;
    localparam int NUM_SCALES = 4;

    // Unit style scale (1.0 in Q3.12) and saturation ceiling
    localparam logic [SCALE_W-1:0] UNIT_SCALE = 15'd4096;
    localparam logic [LIGHT_W-1:0] LIGHT_MAX  = 21'h1FFFFF;

    // Opcodes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LAYER_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_0     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_1     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_2     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_3     = 3'd6;

    typedef struct packed {
        logic                      opcode;
        logic [INDEX_W-1:0]        texel_index;
        logic [7:0]                texel_red;
        logic [7:0]                texel_green;
        logic [7:0]                texel_blue;
        logic signed [COORD_W-1:0] coord_s;
        logic signed [COORD_W-1:0] coord_t;
    } t_in_item;

    typedef struct packed {
        logic [LIGHT_W-1:0] light_red;
        logic [LIGHT_W-1:0] light_green;
        logic [LIGHT_W-1:0] light_blue;
        logic               sample_ok;
    } t_out_item;

endpackage

>>> sv/lightmap_bilinear_style_sampler_unit.sv
// ----------------------------------------------------------------------------
// lightmap_bilinear_style_sampler_unit: bilinear multi-style lightmap sampler
//
// Usage: items enter on the in channel (valid/ready). A write beat stores
// one RGB texel in a single-port texel memory in the cycle it is taken and
// gives no result. A sample beat clamps s,t, filters four texels of each
// active style layer, scales each layer by its Q3.12 style scale and sums
// the layers; one result beat leaves on the out channel.
// Flow: a write beat leaves the block ready for the next beat. A sample
// beat holds the in channel not ready from its beat until its result is
// loaded, through clamp, setup, fetch, drain and finish (clamp goes straight
// to finish with no layers or an empty map). The single memory read port,
// one texel a cycle, sets how long fetch lasts.
// Output: a result register holds the finished beat; the next item can be
// accepted while it waits. A stalled receiver only holds a new sample at
// its last step until the register frees.
// Reset: control and configuration registers return to their reset values
// (empty map, no layers, all scales 1.0); texel memory is not cleared and
// holds undefined data until written.
// Configuration: write only while the block is idle.
// ----------------------------------------------------------------------------
module lightmap_bilinear_style_sampler_unit
    import lmap_pkg::*;
#(
    parameter int MAX_LAYERS  = DEF_MAX_LAYERS,
    parameter int TEXEL_DEPTH = DEF_TEXEL_DEPTH,
    parameter int MAX_DIM     = DEF_MAX_DIM
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // item channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int LAYER_W = $clog2(MAX_LAYERS + 1);
    localparam int IDX_W   = $clog2(TEXEL_DEPTH);
    localparam int ADDR_A  = 2 * DIM_W + $clog2(MAX_LAYERS) + 1;
    localparam int ADDR_W  = (ADDR_A > IDX_W) ? ADDR_A : IDX_W;
    localparam int AREA_W  = 2 * DIM_W;
    localparam int WT_W    = 17;
    localparam int LACC_W  = 24;
    localparam int PROD_W  = LACC_W + SCALE_W;
    localparam int ACC_W   = PROD_W + LAYER_W;
    localparam int FRAC_SH = 20;

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CLAMP  = 3'd1;
    localparam logic [2:0] ST_SETUP  = 3'd2;
    localparam logic [2:0] ST_FETCH  = 3'd3;
    localparam logic [2:0] ST_DRAIN  = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    // corner codes in fetch order
    localparam logic [1:0] CN_00 = 2'd0;
    localparam logic [1:0] CN_01 = 2'd1;
    localparam logic [1:0] CN_11 = 2'd2;
    localparam logic [1:0] CN_10 = 2'd3;

    // configuration registers
    logic [DIM_W-1:0]   r_width, r_height;
    logic [COUNT_W-1:0] r_lcount;
    logic [SCALE_W-1:0] r_scale [NUM_SCALES];

    // sequencer and sample registers
    logic [2:0]              r_state;
    logic signed [COORD_W-1:0] r_cs, r_ct;
    logic [DIM_W-1:0]        r_w, r_s0, r_s1, r_t0, r_t1;
    logic [DIM_W-1:0]        r_h;
    logic [7:0]              r_fs, r_ft;
    logic [LAYER_W-1:0]      r_n, r_layer;
    logic                    r_empty;
    logic [WT_W-1:0]         r_wt [4];
    logic [AREA_W-1:0]       r_area, r_row0, r_row1;
    logic [ADDR_W-1:0]       r_base;
    logic [1:0]              r_k;

    // read pipeline
    logic [23:0]        r_rd_data;
    logic               r_rd_vld, r_rd_zero;
    logic [1:0]         r_rd_k;
    logic [SCALE_W-1:0] r_rd_scale;
    logic               r_scale_pend;
    logic [SCALE_W-1:0] r_pend_scale;
    logic [LACC_W-1:0]  r_lacc [3];
    logic [ACC_W-1:0]   r_acc [3];

    // result register
    logic      r_out_valid;
    t_out_item r_out_data;

    logic [23:0] mem [TEXEL_DEPTH];

    logic mem_we, rd_en, in_fire, out_free;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign mem_we      = in_fire && (i_in_data.opcode == OP_WRITE) &&
                         (32'(i_in_data.texel_index) < TEXEL_DEPTH);
    assign rd_en       = (r_state == ST_FETCH);
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // ---- clamp stage logic ----
    logic [DIM_W-1:0]   w_eff, h_eff;
    logic [LAYER_W-1:0] n_eff;
    logic [13:0]        s_top, t_top, s_cl, t_cl;

    always_comb begin
        w_eff = (32'(r_width) > MAX_DIM) ? DIM_W'(MAX_DIM) : r_width;
        h_eff = (32'(r_height) > MAX_DIM) ? DIM_W'(MAX_DIM) : r_height;
        n_eff = (32'(r_lcount) > MAX_LAYERS) ? LAYER_W'(MAX_LAYERS) : LAYER_W'(r_lcount);
        s_top = {w_eff - 1'b1, 8'd0};
        t_top = {h_eff - 1'b1, 8'd0};
        if (r_cs <= 0) begin
            s_cl = '0;
        end else if (r_cs >= $signed({2'b00, s_top})) begin
            s_cl = s_top;
        end else begin
            s_cl = r_cs[13:0];
        end
        if (r_ct <= 0) begin
            t_cl = '0;
        end else if (r_ct >= $signed({2'b00, t_top})) begin
            t_cl = t_top;
        end else begin
            t_cl = r_ct[13:0];
        end
    end

    // far neighbours, clamped at the edge
    logic [DIM_W:0] s_nx, t_nx;
    assign s_nx = {1'b0, s_cl[13:8]} + 1'b1;
    assign t_nx = {1'b0, t_cl[13:8]} + 1'b1;

    // ---- setup stage logic: corner weights and row offsets ----
    logic [8:0] fs_inv, ft_inv, fs_x, ft_x;
    assign fs_inv = 9'd256 - {1'b0, r_fs};
    assign ft_inv = 9'd256 - {1'b0, r_ft};
    assign fs_x   = {1'b0, r_fs};
    assign ft_x   = {1'b0, r_ft};

    // ---- fetch address ----
    logic [ADDR_W-1:0]  f_addr;
    logic [AREA_W-1:0]  f_row;
    logic [DIM_W-1:0]   f_col;
    logic [LAYER_W+1:0] lyr_x;
    logic [SCALE_W-1:0] f_scale;
    logic               last_corner, more_layers;

    always_comb begin
        f_row = (r_k == CN_00 || r_k == CN_01) ? r_row0 : r_row1;
        f_col = (r_k == CN_00 || r_k == CN_10) ? r_s0 : r_s1;
        f_addr = r_base + ADDR_W'(f_row) + ADDR_W'(f_col);
        lyr_x = (LAYER_W + 2)'(r_layer);
        f_scale = (lyr_x < (LAYER_W + 2)'(NUM_SCALES)) ? r_scale[lyr_x[1:0]] : UNIT_SCALE;
        last_corner = (r_k == CN_10);
        more_layers = ({1'b0, r_layer} + 1'b1) < {1'b0, r_n};
    end

    // ---- configuration writes ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= '0;
            r_height <= '0;
            r_lcount <= '0;
            for (int i = 0; i < NUM_SCALES; i++) begin
                r_scale[i] <= UNIT_SCALE;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MAP_WIDTH:   r_width  <= i_cfg_data[DIM_W-1:0];
                REG_MAP_HEIGHT:  r_height <= i_cfg_data[DIM_W-1:0];
                REG_LAYER_COUNT: r_lcount <= i_cfg_data[COUNT_W-1:0];
                REG_SCALE_0:     r_scale[0] <= i_cfg_data[SCALE_W-1:0];
                REG_SCALE_1:     r_scale[1] <= i_cfg_data[SCALE_W-1:0];
                REG_SCALE_2:     r_scale[2] <= i_cfg_data[SCALE_W-1:0];
                REG_SCALE_3:     r_scale[3] <= i_cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // ---- texel memory: write on a write beat, registered read while fetching ----
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[IDX_W'(i_in_data.texel_index)] <= {i_in_data.texel_red,
                                                  i_in_data.texel_green,
                                                  i_in_data.texel_blue};
        end
        if (rd_en) begin
            r_rd_data <= mem[IDX_W'(f_addr)];
        end
    end

    // ---- sequencer ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= rd_en;
            // drop the result once taken
            if (r_out_valid && i_out_ready && r_state != ST_FINISH) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_fire && i_in_data.opcode == OP_SAMPLE) begin
                        r_state <= ST_CLAMP;
                    end
                end
                ST_CLAMP: begin
                    if (w_eff == '0 || h_eff == '0 || n_eff == '0) begin
                        r_state <= ST_FINISH;
                    end else begin
                        r_state <= ST_SETUP;
                    end
                end
                ST_SETUP: r_state <= ST_FETCH;
                ST_FETCH: begin
                    if (last_corner && !more_layers) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    // last scale step lands on the same edge
                    if (!r_rd_vld) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // ---- datapath registers ----
    logic [LIGHT_W-1:0] light [3];
    logic [ACC_W:0]     rnd;
    logic [ACC_W-FRAC_SH:0] shifted;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            rnd     = {1'b0, r_acc[c]} + (ACC_W + 1)'(1 << (FRAC_SH - 1));
            shifted = rnd[ACC_W:FRAC_SH];
            light[c] = (shifted > (ACC_W - FRAC_SH + 1)'(LIGHT_MAX)) ?
                       LIGHT_MAX : LIGHT_W'(shifted);
        end
    end

    logic [WT_W-1:0]   rd_wt;
    logic [7:0]        rd_byte [3];
    logic [LACC_W:0]   mac_sum [3];
    logic [PROD_W-1:0] scl_prod [3];

    always_comb begin
        rd_wt = r_wt[r_rd_k];
        for (int c = 0; c < 3; c++) begin
            rd_byte[c] = r_rd_zero ? 8'd0 : r_rd_data[16 - 8 * c +: 8];
            mac_sum[c] = ((r_rd_k == CN_00) ? (LACC_W + 1)'(0) : (LACC_W + 1)'(r_lacc[c])) +
                         (LACC_W + 1)'(rd_byte[c]) * (LACC_W + 1)'(rd_wt);
            scl_prod[c] = PROD_W'(r_lacc[c]) * PROD_W'(r_pend_scale);
        end
    end

    always_ff @(posedge i_clk) begin
        // latch coordinates on every accepted beat; only a sample uses them
        if (in_fire) begin
            r_cs <= i_in_data.coord_s;
            r_ct <= i_in_data.coord_t;
        end
        // clamp and split into texel and fraction
        if (r_state == ST_CLAMP) begin
            r_w     <= w_eff;
            r_h     <= h_eff;
            r_n     <= n_eff;
            r_empty <= (w_eff == '0) || (h_eff == '0);
            r_s0    <= s_cl[13:8];
            r_fs    <= s_cl[7:0];
            r_t0    <= t_cl[13:8];
            r_ft    <= t_cl[7:0];
            r_s1    <= (s_nx < {1'b0, w_eff}) ? s_nx[DIM_W-1:0] : s_cl[13:8];
            r_t1    <= (t_nx < {1'b0, h_eff}) ? t_nx[DIM_W-1:0] : t_cl[13:8];
            for (int c = 0; c < 3; c++) begin
                r_acc[c] <= '0;
            end
        end
        // weights, layer area and row offsets
        if (r_state == ST_SETUP) begin
            r_wt[CN_00] <= WT_W'(fs_inv) * WT_W'(ft_inv);
            r_wt[CN_01] <= WT_W'(fs_x) * WT_W'(ft_inv);
            r_wt[CN_11] <= WT_W'(fs_x) * WT_W'(ft_x);
            r_wt[CN_10] <= WT_W'(fs_inv) * WT_W'(ft_x);
            r_area      <= r_w * r_h;
            r_row0      <= r_t0 * r_w;
            r_row1      <= r_t1 * r_w;
            r_base      <= '0;
            r_layer     <= '0;
            r_k         <= CN_00;
        end
        // issue one texel read a cycle, advance layer after the fourth corner
        if (r_state == ST_FETCH) begin
            r_rd_k     <= r_k;
            r_rd_zero  <= !(32'(f_addr) < TEXEL_DEPTH);
            r_rd_scale <= f_scale;
            r_k        <= r_k + 1'b1;
            if (last_corner && more_layers) begin
                r_layer <= r_layer + 1'b1;
                r_base  <= r_base + ADDR_W'(r_area);
            end
        end
        // weighted sum of the four corners of one layer
        if (r_rd_vld) begin
            for (int c = 0; c < 3; c++) begin
                r_lacc[c] <= mac_sum[c][LACC_W-1:0];
            end
        end
        r_scale_pend <= r_rd_vld && (r_rd_k == CN_10);
        if (r_rd_vld && r_rd_k == CN_10) begin
            r_pend_scale <= r_rd_scale;
        end
        // scale the finished layer and add it in
        if (r_scale_pend) begin
            for (int c = 0; c < 3; c++) begin
                r_acc[c] <= r_acc[c] + ACC_W'(scl_prod[c]);
            end
        end
        // round, saturate and load the result
        if (r_state == ST_FINISH && out_free) begin
            r_out_data.light_red   <= r_empty ? '0 : light[0];
            r_out_data.light_green <= r_empty ? '0 : light[1];
            r_out_data.light_blue  <= r_empty ? '0 : light[2];
            r_out_data.sample_ok   <= !r_empty;
        end
    end

endmodule

>>> tb/lightmap_bilinear_style_sampler_unit_test.sv
// ----------------------------------------------------------------------------
// lightmap_bilinear_style_sampler_unit_test: self-checking bench for the sampler
// Fills texels and samples them under a series of map, layer and scale
// settings. Each accepted sample is predicted with exact fixed-point
// bilinear filtering and compared field by field with the result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module lightmap_bilinear_style_sampler_unit_test;
    import lmap_pkg::*;

    localparam int MAX_LAYERS    = DEF_MAX_LAYERS;
    localparam int STORE_DEPTH   = DEF_TEXEL_DEPTH;
    localparam int MAX_DIM       = DEF_MAX_DIM;
    localparam int SCALE_TOP     = 32767;
    localparam int SETTLE_CYCLES = 40;
    localparam int LIMIT_CYCLES  = 500000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 145;

    typedef struct {
        t_in_item item;
        bit       drain_first;
    } t_queued_beat;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_data;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Predictor state: texel copy and register copy
    logic [23:0]        texel_shadow [STORE_DEPTH];
    logic [DIM_W-1:0]   cfg_width = '0;
    logic [DIM_W-1:0]   cfg_height = '0;
    logic [COUNT_W-1:0] cfg_layers = '0;
    logic [SCALE_W-1:0] cfg_scale [NUM_SCALES] = '{default: UNIT_SCALE};

    // Stimulus bookkeeping
    bit            slot_planned [STORE_DEPTH];
    t_queued_beat  beat_backlog [$];
    t_out_item     light_expected [$];
    bit            drain_next = 1'b0;
    bit            in_taken = 1'b0;
    int            phase_items = 0;
    int            idle_pct = 0;
    int            stall_pct = 0;
    int            fail_count = 0;

    lightmap_bilinear_style_sampler_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        fail_count++;
    endtask

    function automatic int clip_dim(input int d);
        return (d > MAX_DIM) ? MAX_DIM : d;
    endfunction

    // Clamp s,t to the map and find the four corner columns/rows and fractions
    function automatic void locate_corners(input logic signed [COORD_W-1:0] s,
                                           input logic signed [COORD_W-1:0] t,
                                           input int w, input int h,
                                           output int col0, output int col1,
                                           output int row0, output int row1,
                                           output int frac_s, output int frac_t);
        int top_s;
        int top_t;
        int cs;
        int ct;
        top_s = (w - 1) * 256;
        top_t = (h - 1) * 256;
        cs = (s <= 0) ? 0 : ((s >= top_s) ? top_s : int'(s));
        ct = (t <= 0) ? 0 : ((t >= top_t) ? top_t : int'(t));
        col0 = cs >> 8;
        row0 = ct >> 8;
        frac_s = cs & 255;
        frac_t = ct & 255;
        col1 = (col0 + 1 < w) ? col0 + 1 : col0;
        row1 = (row0 + 1 < h) ? row0 + 1 : row0;
    endfunction

    // Filter every active layer, scale, sum and round to 8 fraction bits
    function automatic t_out_item sample_light(input t_in_item it);
        t_out_item         r;
        int                w, h, n, lay, k, ch, base;
        int                c0, c1, r0, r1, fs, ft;
        int                idx [4];
        logic [23:0]       px [4];
        longint unsigned   chan [4];
        longint unsigned   acc [3];
        longint unsigned   row_a, row_b, scale, v;
        r = '0;
        w = clip_dim(cfg_width);
        h = clip_dim(cfg_height);
        if (w == 0 || h == 0)
            return r;
        locate_corners(it.coord_s, it.coord_t, w, h, c0, c1, r0, r1, fs, ft);
        n = (cfg_layers > MAX_LAYERS) ? MAX_LAYERS : cfg_layers;
        acc = '{default: 0};
        for (lay = 0; lay < n; lay++) begin
            base = lay * w * h;
            idx[0] = base + r0 * w + c0;
            idx[1] = base + r0 * w + c1;
            idx[2] = base + r1 * w + c1;
            idx[3] = base + r1 * w + c0;
            for (k = 0; k < 4; k++) begin
                px[k] = (idx[k] < STORE_DEPTH) ? texel_shadow[idx[k]] : 24'h0;
            end
            scale = (lay < NUM_SCALES) ? cfg_scale[lay] : UNIT_SCALE;
            for (ch = 0; ch < 3; ch++) begin
                for (k = 0; k < 4; k++) begin
                    chan[k] = (px[k] >> (16 - 8 * ch)) & 24'hFF;
                end
                row_a = chan[0] * (256 - fs) + chan[1] * fs;
                row_b = chan[3] * (256 - fs) + chan[2] * fs;
                acc[ch] += (row_a * (256 - ft) + row_b * ft) * scale;
            end
        end
        for (ch = 0; ch < 3; ch++) begin
            v = (acc[ch] + (64'd1 << 19)) >> 20;
            if (v > LIGHT_MAX)
                v = LIGHT_MAX;
            case (ch)
                0: r.light_red = v[LIGHT_W-1:0];
                1: r.light_green = v[LIGHT_W-1:0];
                default: r.light_blue = v[LIGHT_W-1:0];
            endcase
        end
        r.sample_ok = 1'b1;
        return r;
    endfunction

    // Monitor: check result beats, update predictor on input beats and writes
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
            cfg_width = '0;
            cfg_height = '0;
            cfg_layers = '0;
            cfg_scale = '{default: UNIT_SCALE};
        end else begin
            in_taken <= i_in_valid && o_in_ready;
            if (o_out_valid && i_out_ready) begin
                if (light_expected.size() == 0) begin
                    report_mismatch("result beat with no sample waiting");
                end else begin
                    want = light_expected.pop_front();
                    if (o_out_data.light_red !== want.light_red)
                        report_mismatch($sformatf("light_red got %0d expected %0d",
                                                  o_out_data.light_red, want.light_red));
                    if (o_out_data.light_green !== want.light_green)
                        report_mismatch($sformatf("light_green got %0d expected %0d",
                                                  o_out_data.light_green, want.light_green));
                    if (o_out_data.light_blue !== want.light_blue)
                        report_mismatch($sformatf("light_blue got %0d expected %0d",
                                                  o_out_data.light_blue, want.light_blue));
                    if (o_out_data.sample_ok !== want.sample_ok)
                        report_mismatch($sformatf("sample_ok got %0b expected %0b",
                                                  o_out_data.sample_ok, want.sample_ok));
                end
            end
            if (i_in_valid && o_in_ready) begin
                if (i_in_data.opcode == OP_WRITE) begin
                    if (i_in_data.texel_index < STORE_DEPTH)
                        texel_shadow[i_in_data.texel_index] = {i_in_data.texel_red,
                                                               i_in_data.texel_green,
                                                               i_in_data.texel_blue};
                end else begin
                    light_expected.push_back(sample_light(i_in_data));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_MAP_WIDTH:   cfg_width = i_cfg_data[DIM_W-1:0];
                    REG_MAP_HEIGHT:  cfg_height = i_cfg_data[DIM_W-1:0];
                    REG_LAYER_COUNT: cfg_layers = i_cfg_data[COUNT_W-1:0];
                    REG_SCALE_0:     cfg_scale[0] = i_cfg_data[SCALE_W-1:0];
                    REG_SCALE_1:     cfg_scale[1] = i_cfg_data[SCALE_W-1:0];
                    REG_SCALE_2:     cfg_scale[2] = i_cfg_data[SCALE_W-1:0];
                    REG_SCALE_3:     cfg_scale[3] = i_cfg_data[SCALE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Driver: present the next beat, hold until taken, idle and stall at random
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
            if (i_in_valid && !in_taken) begin
                // hold the beat until accepted
            end else if (beat_backlog.size() == 0 || $urandom_range(99) < idle_pct ||
                         (beat_backlog[0].drain_first && light_expected.size() != 0)) begin
                i_in_valid <= 1'b0;
            end else begin
                i_in_data <= beat_backlog[0].item;
                beat_backlog.pop_front();
                i_in_valid <= 1'b1;
            end
        end
    end

    task automatic wait_idle();
        do
            @(posedge i_clk);
        while (beat_backlog.size() != 0 || i_in_valid || light_expected.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val[CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Write every register, then let the last write land before planning
    task automatic set_config(input int w, input int h, input int n,
                              input int s0, input int s1, input int s2, input int s3);
        write_reg(REG_MAP_WIDTH, w);
        write_reg(REG_MAP_HEIGHT, h);
        write_reg(REG_LAYER_COUNT, n);
        write_reg(REG_SCALE_0, s0);
        write_reg(REG_SCALE_1, s1);
        write_reg(REG_SCALE_2, s2);
        write_reg(REG_SCALE_3, s3);
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick_byte();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return 8'h00;
        if (roll < 20)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    function automatic int pick_dim();
        int roll;
        roll = $urandom_range(99);
        if (roll < 5)
            return 0;
        if (roll < 10)
            return $urandom_range(63, MAX_DIM + 1);
        if (roll < 20)
            return MAX_DIM;
        return $urandom_range(8, 1);
    endfunction

    function automatic int pick_scale();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return 0;
        if (roll < 20)
            return SCALE_TOP;
        if (roll < 35)
            return UNIT_SCALE;
        return $urandom_range(SCALE_TOP, 0);
    endfunction

    // Mostly near the map, sometimes anywhere in the signed range
    function automatic int pick_coord(input int d);
        if ($urandom_range(99) < 25)
            return int'($signed(16'($urandom)));
        return int'($urandom_range(d * 256 + 511, 0)) - 256;
    endfunction

    task automatic push_beat(input t_in_item it);
        t_queued_beat b;
        b.item = it;
        b.drain_first = drain_next;
        drain_next = 1'b0;
        beat_backlog.push_back(b);
        phase_items++;
    endtask

    task automatic push_write(input int idx, input logic [7:0] r,
                              input logic [7:0] g, input logic [7:0] b);
        t_in_item it;
        it.opcode = OP_WRITE;
        it.texel_index = idx[INDEX_W-1:0];
        it.texel_red = r;
        it.texel_green = g;
        it.texel_blue = b;
        it.coord_s = 16'($urandom);
        it.coord_t = 16'($urandom);
        slot_planned[idx] = 1'b1;
        push_beat(it);
    endtask

    // Fill any texel the sample would read that was never written, then sample
    task automatic push_sample(input int cs, input int ct);
        t_in_item it;
        int w, h, n, lay, k, base;
        int c0, c1, r0, r1, fs, ft;
        int slot [4];
        w = clip_dim(cfg_width);
        h = clip_dim(cfg_height);
        n = (cfg_layers > MAX_LAYERS) ? MAX_LAYERS : cfg_layers;
        if (w != 0 && h != 0) begin
            locate_corners(cs[COORD_W-1:0], ct[COORD_W-1:0], w, h, c0, c1, r0, r1, fs, ft);
            for (lay = 0; lay < n; lay++) begin
                base = lay * w * h;
                slot[0] = base + r0 * w + c0;
                slot[1] = base + r0 * w + c1;
                slot[2] = base + r1 * w + c1;
                slot[3] = base + r1 * w + c0;
                for (k = 0; k < 4; k++) begin
                    if (slot[k] < STORE_DEPTH && !slot_planned[slot[k]])
                        push_write(slot[k], pick_byte(), pick_byte(), pick_byte());
                end
            end
        end
        it.opcode = OP_SAMPLE;
        it.texel_index = INDEX_W'($urandom);
        it.texel_red = 8'($urandom);
        it.texel_green = 8'($urandom);
        it.texel_blue = 8'($urandom);
        it.coord_s = cs[COORD_W-1:0];
        it.coord_t = ct[COORD_W-1:0];
        push_beat(it);
    endtask

    // Stimulus
    initial begin
        int p;
        bit halfway;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty map straight out of reset, with texel extremes at both ends
        push_write(STORE_DEPTH - 1, 8'hFF, 8'hFF, 8'hFF);
        push_write(0, 8'h00, 8'h00, 8'h00);
        push_sample(-32768, 32767);
        push_sample(32767, -32768);
        wait_idle();

        // Zero width, then zero height
        set_config(0, 5, 2, UNIT_SCALE, UNIT_SCALE, UNIT_SCALE, UNIT_SCALE);
        push_sample(256, 256);
        wait_idle();
        set_config(5, 0, 2, UNIT_SCALE, UNIT_SCALE, UNIT_SCALE, UNIT_SCALE);
        push_sample(256, 256);
        wait_idle();

        // No layers: zero colour but a valid map
        set_config(3, 2, 0, UNIT_SCALE, UNIT_SCALE, UNIT_SCALE, UNIT_SCALE);
        push_sample(300, 100);
        wait_idle();

        // Oversized width and too many layers, scales at their extremes
        set_config(63, 1, 7, SCALE_TOP, 0, 1, UNIT_SCALE);
        push_sample(32767, -32768);
        wait_idle();

        // Full fractions and the far edge, once after a drain
        set_config(2, 2, 2, pick_scale(), pick_scale(), 0, 0);
        push_sample(16'h00FF, 16'h00FF);
        drain_next = 1'b1;
        push_sample(16'h0080, 16'h0100);

        // Random phases, cycling through the idling modes
        for (p = 0; p < RANDOM_PHASES; p++) begin
            wait_idle();
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 53; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 53; end
                default: begin idle_pct = 9; stall_pct = 9; end
            endcase
            if (p == RANDOM_PHASES - 1)
                set_config(MAX_DIM, MAX_DIM, MAX_LAYERS,
                           SCALE_TOP, SCALE_TOP, SCALE_TOP, SCALE_TOP);
            else
                set_config(pick_dim(), pick_dim(),
                           ($urandom_range(99) < 5) ? 0 :
                           (($urandom_range(99) < 8) ? $urandom_range(7, 5) :
                                                       $urandom_range(4, 1)),
                           pick_scale(), pick_scale(), pick_scale(), pick_scale());
            phase_items = 0;
            halfway = 1'b0;
            while (phase_items < PHASE_ITEMS) begin
                if (!halfway && phase_items >= PHASE_ITEMS / 2) begin
                    drain_next = 1'b1;
                    halfway = 1'b1;
                end
                if ($urandom_range(99) < 15)
                    push_write($urandom_range(STORE_DEPTH - 1, 0),
                               pick_byte(), pick_byte(), pick_byte());
                else
                    push_sample(pick_coord(clip_dim(cfg_width)),
                                pick_coord(clip_dim(cfg_height)));
            end
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("lightmap_bilinear_style_sampler_unit_test passed");
        end else begin
            $display("lightmap_bilinear_style_sampler_unit_test failed");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #(LIMIT_CYCLES * 12);
        $display("lightmap_bilinear_style_sampler_unit_test failed");
        $finish;
    end

endmodule

>>> filelist.f
sv/lmap_pkg.sv
sv/lightmap_bilinear_style_sampler_unit.sv
tb/lightmap_bilinear_style_sampler_unit_test.sv
